>>> rtl/core/rbvi_pkg.sv
// rbvi_pkg: shared types and constants for the rigid body velocity integrator.
// No dependencies; used by rbvi_arith and rigid_body_velocity_integrator_top.
package rbvi_pkg;

  // serial arithmetic operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  // one bit of multiplier, quotient or root per cycle
  localparam logic [6:0] MUL_STEPS  = 7'd32;
  localparam logic [6:0] DIV_STEPS  = 7'd64;
  localparam logic [6:0] SQRT_STEPS = 7'd32;

  localparam int ACC_W = 66;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } arith_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

>>> rtl/core/rbvi_arith.sv
// rbvi_arith: bit-serial shared unit: signed x unsigned multiply, unsigned
// divide and integer square root, one bit per cycle. Depends on rbvi_pkg.
module rbvi_arith (
  input  logic                                    clk,
  input  logic                                    rst,
  input  rbvi_pkg::arith_cmd_t                    cmd,
  input  logic signed [rbvi_pkg::ACC_W-1:0]       opa,
  input  logic [31:0]                             opb,
  output logic                                    done,
  output logic signed [rbvi_pkg::ACC_W-1:0]       result
);

  logic                              busy;
  logic [1:0]                        op;
  logic [6:0]                        cnt;
  logic signed [rbvi_pkg::ACC_W-1:0] acc;
  logic signed [rbvi_pkg::ACC_W-1:0] opnd;
  logic [63:0]                       sh;
  logic [33:0]                       rem;

  // divide step
  logic [32:0] dv_t, dv_d;
  logic        dv_ge;
  // root step
  logic [35:0] sq_r, sq_t;
  logic        sq_ge;

  always_comb begin
    dv_t  = {rem[31:0], sh[63]};
    dv_d  = {1'b0, opnd[31:0]};
    dv_ge = dv_t >= dv_d;
    sq_r  = {rem, sh[63:62]};
    sq_t  = {2'b00, acc[31:0], 2'b01};
    sq_ge = sq_r >= sq_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        acc  <= '0;
        rem  <= '0;
        if (cmd.op == rbvi_pkg::OP_MUL) begin
          opnd <= opa;
          sh   <= {32'b0, opb};
          cnt  <= rbvi_pkg::MUL_STEPS;
        end else begin
          opnd <= {34'b0, opb};
          sh   <= opa[63:0];
          cnt  <= (cmd.op == rbvi_pkg::OP_DIV) ? rbvi_pkg::DIV_STEPS
                                                : rbvi_pkg::SQRT_STEPS;
        end
      end else if (busy) begin
        unique case (op)
          rbvi_pkg::OP_MUL: begin
            acc <= (acc <<< 1) + (sh[31] ? opnd : '0);
            sh  <= sh << 1;
          end
          rbvi_pkg::OP_DIV: begin
            rem <= {1'b0, (dv_ge ? dv_t - dv_d : dv_t)};
            acc <= {acc[rbvi_pkg::ACC_W-2:0], dv_ge};
            sh  <= sh << 1;
          end
          default: begin
            rem <= sq_ge ? 34'(sq_r - sq_t) : 34'(sq_r);
            acc <= {acc[rbvi_pkg::ACC_W-2:0], sq_ge};
            sh  <= sh << 2;
          end
        endcase
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

endmodule

>>> rtl/core/rigid_body_velocity_integrator_top.sv
// rigid_body_velocity_integrator_top: Euler velocity update with drag, gravity
// and axis locks. Depends on rbvi_pkg and rbvi_arith.
// One beat is in flight at a time, set by the single bit-serial arith unit that
// serves every multiply, divide and root step in turn; drag and gravity add
// steps to a beat. A new beat is taken while a result waits.
// Reset: synchronous; clears velocities, config registers and handshake state.
module rigid_body_velocity_integrator_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input beat
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [16:0]        step_time,
  input  logic signed [31:0] lin_accel_x,
  input  logic signed [31:0] lin_accel_y,
  input  logic signed [31:0] lin_accel_z,
  input  logic signed [31:0] ang_accel_x,
  input  logic signed [31:0] ang_accel_y,
  input  logic signed [31:0] ang_accel_z,
  // result beat
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] lin_vel_x,
  output logic signed [31:0] lin_vel_y,
  output logic signed [31:0] lin_vel_z,
  output logic signed [31:0] ang_vel_x,
  output logic signed [31:0] ang_vel_y,
  output logic signed [31:0] ang_vel_z,
  output logic signed [31:0] move_x,
  output logic signed [31:0] move_y,
  output logic signed [31:0] move_z,
  output logic signed [31:0] turn_x,
  output logic signed [31:0] turn_y,
  output logic signed [31:0] turn_z
);

  // register map, word index
  localparam logic [2:0] REG_GRAV_X = 3'd0;
  localparam logic [2:0] REG_GRAV_Y = 3'd1;
  localparam logic [2:0] REG_GRAV_Z = 3'd2;
  localparam logic [2:0] REG_LCOEF  = 3'd3;
  localparam logic [2:0] REG_ACOEF  = 3'd4;
  localparam logic [2:0] REG_MODE   = 3'd5;

  // sequencer states: issue states start the arith unit, *_W wait for it
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQ    = 5'd1;   // |v_i|^2
  localparam logic [4:0] S_SQ_W  = 5'd2;
  localparam logic [4:0] S_RT    = 5'd3;   // norm = isqrt(sum)
  localparam logic [4:0] S_RT_W  = 5'd4;
  localparam logic [4:0] S_DM    = 5'd5;   // coef * |v_i|
  localparam logic [4:0] S_DM_W  = 5'd6;
  localparam logic [4:0] S_DD    = 5'd7;   // ... / norm
  localparam logic [4:0] S_DD_W  = 5'd8;
  localparam logic [4:0] S_GM    = 5'd9;   // gravity * dt
  localparam logic [4:0] S_GM_W  = 5'd10;
  localparam logic [4:0] S_AM    = 5'd11;  // (accel + drag) * dt
  localparam logic [4:0] S_AM_W  = 5'd12;
  localparam logic [4:0] S_MV    = 5'd13;  // new velocity * dt
  localparam logic [4:0] S_MV_W  = 5'd14;
  localparam logic [4:0] S_OUT   = 5'd15;

  localparam int ACC_W = rbvi_pkg::ACC_W;

  // config registers
  logic signed [31:0] grav [3];
  logic [30:0]        lcoef, acoef;
  logic [8:0]         mode;

  // working state
  logic [4:0]         state;
  logic               body;      // 0 linear, 1 angular
  logic [1:0]         axis;
  logic [31:0]        dt;
  logic signed [31:0] accel [2][3];
  logic signed [31:0] vel   [2][3];
  logic signed [31:0] mv    [2][3];
  logic signed [32:0] drag  [3];
  logic [63:0]        sum;
  logic [63:0]        prod;
  logic [31:0]        norm;
  logic signed [ACC_W-1:0] nv;

  // result register
  logic signed [31:0] o_vel [2][3];
  logic signed [31:0] o_mv  [2][3];

  // arith unit hookup
  rbvi_pkg::arith_cmd_t    cmd;
  logic signed [ACC_W-1:0] opa;
  logic [31:0]             opb;
  logic                    ar_done;
  logic signed [ACC_W-1:0] ar_res;
  logic signed [ACC_W-1:0] scaled;   // product >> FRAC_BITS, floor

  rbvi_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .opa    (opa),
    .opb    (opb),
    .done   (ar_done),
    .result (ar_res)
  );

  // ---------------------------------------------------------------------------
  // config port: always ready, plain register file
  // ---------------------------------------------------------------------------
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav[0] <= '0;
      grav[1] <= '0;
      grav[2] <= '0;
      lcoef   <= '0;
      acoef   <= '0;
      mode    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_GRAV_X: grav[0] <= pwdata;
        REG_GRAV_Y: grav[1] <= pwdata;
        REG_GRAV_Z: grav[2] <= pwdata;
        REG_LCOEF:  lcoef   <= pwdata[30:0];
        REG_ACOEF:  acoef   <= pwdata[30:0];
        REG_MODE:   mode    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_GRAV_X: prdata = grav[0];
      REG_GRAV_Y: prdata = grav[1];
      REG_GRAV_Z: prdata = grav[2];
      REG_LCOEF:  prdata = {1'b0, lcoef};
      REG_ACOEF:  prdata = {1'b0, acoef};
      REG_MODE:   prdata = {23'b0, mode};
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // per-body mode decode and operand selection
  // ---------------------------------------------------------------------------
  logic               drag_en, grav_en, lock;
  logic [30:0]        coef;
  logic signed [31:0] v_cur;
  logic [31:0]        mag;
  logic [31:0]        dt_in;
  logic [31:0]        dt_one;

  assign drag_en = body ? mode[2] : mode[0];
  assign grav_en = !body && mode[1];
  assign lock    = body ? mode[6 + 32'(axis)] : mode[3 + 32'(axis)];
  assign coef    = body ? acoef : lcoef;
  assign v_cur   = vel[body][axis];
  // |v|; -(-2^31) wraps to 2^31, which is right as unsigned
  assign mag     = v_cur[31] ? 32'(-v_cur) : v_cur;
  assign dt_one  = 32'(1) << FRAC_BITS;
  assign dt_in   = {15'b0, step_time};
  assign scaled  = ar_res >>> FRAC_BITS;

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = rbvi_pkg::OP_MUL;
    opa       = '0;
    opb       = dt;
    case (state)
      S_SQ: begin
        cmd.start = 1'b1;
        opa       = {34'b0, mag};
        opb       = mag;
      end
      S_RT: begin
        cmd.start = 1'b1;
        cmd.op    = rbvi_pkg::OP_SQRT;
        opa       = {2'b0, sum};
      end
      S_DM: begin
        cmd.start = 1'b1;
        opa       = {34'b0, mag};
        opb       = {1'b0, coef};
      end
      S_DD: begin
        cmd.start = 1'b1;
        cmd.op    = rbvi_pkg::OP_DIV;
        opa       = {2'b0, prod};
        opb       = norm;
      end
      S_GM: begin
        cmd.start = 1'b1;
        opa       = ACC_W'(grav[axis]);
      end
      S_AM: begin
        cmd.start = 1'b1;
        opa       = ACC_W'(accel[body][axis]) + ACC_W'(drag[axis]);
      end
      S_MV: begin
        cmd.start = 1'b1;
        opa       = ACC_W'(v_cur);
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic               in_acc, out_take;
  logic [63:0]        sum_next;
  logic signed [ACC_W-1:0] nv_next;
  logic [32:0]        dq;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign sum_next = sum + ar_res[63:0];
  assign nv_next  = (grav_en ? nv : ACC_W'(v_cur)) + scaled;
  assign dq       = {1'b0, ar_res[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int i = 0; i < 3; i++) begin
          vel[b][i] <= '0;
        end
      end
    end else begin
      if (out_take) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            dt          <= (dt_in > dt_one) ? dt_one : dt_in;
            accel[0][0] <= lin_accel_x;
            accel[0][1] <= lin_accel_y;
            accel[0][2] <= lin_accel_z;
            accel[1][0] <= ang_accel_x;
            accel[1][1] <= ang_accel_y;
            accel[1][2] <= ang_accel_z;
            body        <= 1'b0;
            axis        <= 2'd0;
            sum         <= '0;
            for (int i = 0; i < 3; i++) drag[i] <= '0;
            state <= mode[0] ? S_SQ : (mode[1] ? S_GM : S_AM);
          end
        end
        S_SQ:   state <= S_SQ_W;
        S_SQ_W: begin
          if (ar_done) begin
            sum <= sum_next;
            if (axis == 2'd2) begin
              axis <= 2'd0;
              // zero old velocity: no drag
              state <= (sum_next != 64'd0) ? S_RT : (grav_en ? S_GM : S_AM);
            end else begin
              axis  <= axis + 2'd1;
              state <= S_SQ;
            end
          end
        end
        S_RT:   state <= S_RT_W;
        S_RT_W: begin
          if (ar_done) begin
            norm  <= ar_res[31:0];
            state <= S_DM;
          end
        end
        S_DM:   state <= S_DM_W;
        S_DM_W: begin
          if (ar_done) begin
            prod  <= ar_res[63:0];
            state <= S_DD;
          end
        end
        S_DD:   state <= S_DD_W;
        S_DD_W: begin
          if (ar_done) begin
            // drag opposes the old velocity
            drag[axis] <= (!v_cur[31] && v_cur != '0) ? -dq : dq;
            if (axis == 2'd2) begin
              axis  <= 2'd0;
              state <= grav_en ? S_GM : S_AM;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_DM;
            end
          end
        end
        S_GM:   state <= S_GM_W;
        S_GM_W: begin
          if (ar_done) begin
            nv    <= ACC_W'(v_cur) + scaled;
            state <= S_AM;
          end
        end
        S_AM:   state <= S_AM_W;
        S_AM_W: begin
          if (ar_done) begin
            vel[body][axis] <= lock ? '0 : rbvi_pkg::sat32(nv_next);
            state           <= S_MV;
          end
        end
        S_MV:   state <= S_MV_W;
        S_MV_W: begin
          if (ar_done) begin
            mv[body][axis] <= rbvi_pkg::sat32(scaled);
            if (axis == 2'd2) begin
              axis <= 2'd0;
              if (!body) begin
                body <= 1'b1;
                sum  <= '0;
                for (int i = 0; i < 3; i++) drag[i] <= '0;
                state <= mode[2] ? S_SQ : S_AM;
              end else begin
                state <= S_OUT;
              end
            end else begin
              axis  <= axis + 2'd1;
              state <= grav_en ? S_GM : S_AM;
            end
          end
        end
        S_OUT: begin
          // hand off once the result register is free
          if (!out_valid || !out_stall) begin
            o_vel     <= vel;
            o_mv      <= mv;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign lin_vel_x = o_vel[0][0];
  assign lin_vel_y = o_vel[0][1];
  assign lin_vel_z = o_vel[0][2];
  assign ang_vel_x = o_vel[1][0];
  assign ang_vel_y = o_vel[1][1];
  assign ang_vel_z = o_vel[1][2];
  assign move_x    = o_mv[0][0];
  assign move_y    = o_mv[0][1];
  assign move_z    = o_mv[0][2];
  assign turn_x    = o_mv[1][0];
  assign turn_y    = o_mv[1][1];
  assign turn_z    = o_mv[1][2];

endmodule
